// ===== rtl/core/slmp_pkg.sv =====
package slmp_pkg;

  localparam int NCH        = 3;
  localparam int PWM_PERIOD = 4096;
  localparam int FRAC_BITS  = 7;

  localparam int OP_W     = 2;
  localparam int PORT_W   = 2;
  localparam int GOAL_W   = 9;
  localparam int TIME_W   = 48;
  localparam int TMO_W    = 31;
  localparam int SLEW_W   = 16;
  localparam int ACT_W    = 16;
  localparam int CMP_W    = 12;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_GOAL   = 2'd1;
  localparam logic [OP_W-1:0] OP_ENABLE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR    = 3'd4;

  localparam logic [TMO_W-1:0]  TIMEOUT_RST  = TMO_W'(1000000);
  localparam logic [SLEW_W-1:0] SLEW_RST     = SLEW_W'(16'h0180);
  localparam logic [SLEW_W-1:0] STOP_MIN_SLEW = SLEW_W'(16'h0080);

  localparam logic [CMP_W-1:0] CMP_SCALE = CMP_W'(PWM_PERIOD / 256);

endpackage

// ===== rtl/core/slmp_if.sv =====
interface slmp_in_if import slmp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [PORT_W-1:0]        port;
  logic signed [GOAL_W-1:0] goal_pwm;
  logic                     enable_value;
  logic                     estop;
  logic [TIME_W-1:0]        now_us;

  modport source (output valid, operation, port, goal_pwm, enable_value, estop, now_us,
                  input ready);
  modport sink   (input valid, operation, port, goal_pwm, enable_value, estop, now_us,
                  output ready);
endinterface

interface slmp_out_if import slmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMP_W-1:0] cmp_a0;
  logic [CMP_W-1:0] cmp_b0;
  logic [CMP_W-1:0] cmp_a1;
  logic [CMP_W-1:0] cmp_b1;
  logic [CMP_W-1:0] cmp_a2;
  logic [CMP_W-1:0] cmp_b2;
  logic [NCH-1:0]   enable_bits;
  logic             watchdog_active;
  logic [CNT_W-1:0] watchdog_events;

  modport source (output valid, cmp_a0, cmp_b0, cmp_a1, cmp_b1, cmp_a2, cmp_b2,
                  enable_bits, watchdog_active, watchdog_events, input ready);
  modport sink   (input valid, cmp_a0, cmp_b0, cmp_a1, cmp_b1, cmp_a2, cmp_b2,
                  enable_bits, watchdog_active, watchdog_events, output ready);
endinterface

interface slmp_cfg_if import slmp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TMO_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/slew_limited_motor_pwm_core.sv =====
// Three-channel slew-limited motor PWM core with command watchdog. Every input beat
// (tick, set goal, set enable) yields exactly one result beat holding the compare
// values, enable bits and watchdog status after that beat. One beat is taken per clock
// as long as the result side takes each result: the whole three-channel update (time
// difference, watchdog compare, per-channel clamp and add, compare scaling) is
// combinational between the input handshake and the state registers, and those
// registers drive the result beat directly. Configuration writes are always accepted.
module slew_limited_motor_pwm_core import slmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  slmp_in_if.sink     in_ch,
  slmp_out_if.source  out_ch,
  slmp_cfg_if.sink    cfg_ch
);

  // configuration
  logic [TMO_W-1:0]  tmo_r;
  logic [SLEW_W-1:0] slew_r [NCH];
  logic              pair_r;

  // state
  logic signed [GOAL_W-1:0] goal_r [NCH];
  logic signed [ACT_W-1:0]  act_r  [NCH];
  logic [NCH-1:0]           en_r;
  logic [TIME_W-1:0]        last_r;
  logic                     wd_flag_r;
  logic [CNT_W-1:0]         wd_cnt_r;
  logic [CMP_W-1:0]         cmp_a_r [NCH];
  logic [CMP_W-1:0]         cmp_b_r [NCH];
  logic                     out_vld_r;

  logic                     acc;
  logic [TIME_W-1:0]        elapsed;
  logic                     fire;
  logic                     stop;
  logic                     port_ok;
  logic signed [GOAL_W-1:0] goal_sat;
  logic [SLEW_W-1:0]        lim    [NCH];
  logic signed [ACT_W+1:0]  target [NCH];
  logic signed [ACT_W+1:0]  diff   [NCH];
  logic signed [ACT_W+1:0]  lim_s  [NCH];
  logic signed [ACT_W-1:0]  act_nxt [NCH];
  logic signed [GOAL_W-1:0] duty   [NCH];
  logic [GOAL_W-1:0]        mag    [NCH];
  logic [CMP_W-1:0]         cmp_a_nxt [NCH];
  logic [CMP_W-1:0]         cmp_b_nxt [NCH];

  assign in_ch.ready  = !out_vld_r || out_ch.ready;
  assign acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = out_vld_r;
  assign out_ch.cmp_a0          = cmp_a_r[0];
  assign out_ch.cmp_b0          = cmp_b_r[0];
  assign out_ch.cmp_a1          = cmp_a_r[1];
  assign out_ch.cmp_b1          = cmp_b_r[1];
  assign out_ch.cmp_a2          = cmp_a_r[2];
  assign out_ch.cmp_b2          = cmp_b_r[2];
  assign out_ch.enable_bits     = en_r;
  assign out_ch.watchdog_active = wd_flag_r;
  assign out_ch.watchdog_events = wd_cnt_r;

  assign port_ok = in_ch.port < PORT_W'(NCH);
  // -256 is outside the goal range, pull it in to -255
  assign goal_sat = (in_ch.goal_pwm == {1'b1, {(GOAL_W-1){1'b0}}}) ?
                    {1'b1, {(GOAL_W-2){1'b0}}, 1'b1} : in_ch.goal_pwm;

  always_comb begin
    elapsed = in_ch.now_us - last_r;
    fire    = (tmo_r != '0) && (elapsed > TIME_W'(tmo_r));
    stop    = in_ch.estop || fire;
    for (int i = 0; i < NCH; i++) begin
      lim[i]    = (stop && slew_r[i] < STOP_MIN_SLEW) ? STOP_MIN_SLEW : slew_r[i];
      lim_s[i]  = $signed({2'b00, lim[i]});
      target[i] = stop ? '0 : (ACT_W+2)'($signed({goal_r[i], {FRAC_BITS{1'b0}}}));
      diff[i]   = target[i] - (ACT_W+2)'(act_r[i]);
      if (diff[i] < -lim_s[i]) begin
        diff[i] = -lim_s[i];
      end
      if (diff[i] > lim_s[i]) begin
        diff[i] = lim_s[i];
      end
      act_nxt[i] = act_r[i] + diff[i][ACT_W-1:0];
      // arithmetic shift gives floor for negatives
      duty[i] = act_nxt[i][ACT_W-1:FRAC_BITS];
      mag[i]  = duty[i][GOAL_W-1] ? GOAL_W'(-duty[i]) : GOAL_W'(duty[i]);
      cmp_a_nxt[i] = duty[i][GOAL_W-1] ? '0 : CMP_W'(mag[i]) * CMP_SCALE;
      cmp_b_nxt[i] = duty[i][GOAL_W-1] ? CMP_W'(mag[i]) * CMP_SCALE : '0;
    end
    if (pair_r) begin
      cmp_a_nxt[2] = cmp_a_nxt[1];
      cmp_b_nxt[2] = cmp_b_nxt[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r  <= TIMEOUT_RST;
      pair_r <= 1'b1;
      for (int i = 0; i < NCH; i++) begin
        slew_r[i] <= SLEW_RST;
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TIMEOUT: tmo_r     <= cfg_ch.data;
        REG_SLEW0:   slew_r[0] <= cfg_ch.data[SLEW_W-1:0];
        REG_SLEW1:   slew_r[1] <= cfg_ch.data[SLEW_W-1:0];
        REG_SLEW2:   slew_r[2] <= cfg_ch.data[SLEW_W-1:0];
        REG_PAIR:    pair_r    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      en_r      <= '0;
      last_r    <= '0;
      wd_flag_r <= 1'b0;
      wd_cnt_r  <= '0;
      for (int i = 0; i < NCH; i++) begin
        goal_r[i]  <= '0;
        act_r[i]   <= '0;
        cmp_a_r[i] <= '0;
        cmp_b_r[i] <= '0;
      end
    end else begin
      if (acc) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (acc) begin
        case (in_ch.operation)
          OP_TICK: begin
            for (int i = 0; i < NCH; i++) begin
              act_r[i]   <= act_nxt[i];
              cmp_a_r[i] <= cmp_a_nxt[i];
              cmp_b_r[i] <= cmp_b_nxt[i];
            end
            wd_flag_r <= fire;
            if (fire && !wd_flag_r) begin
              wd_cnt_r <= wd_cnt_r + 1'b1;
            end
          end
          OP_GOAL: begin
            if (port_ok) begin
              goal_r[in_ch.port] <= goal_sat;
              last_r             <= in_ch.now_us;
            end
          end
          OP_ENABLE: begin
            if (port_ok) begin
              last_r <= in_ch.now_us;
              if (in_ch.enable_value != en_r[in_ch.port]) begin
                // channel 1 change carries over to channel 2 in pair mode
                if (pair_r && in_ch.port == PORT_W'(1)) begin
                  en_r[2:1] <= {2{in_ch.enable_value}};
                end else begin
                  en_r[in_ch.port] <= in_ch.enable_value;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_cnt_on_rise: assert property (@(posedge clk) disable iff (!rst_n)
    wd_cnt_r != $past(wd_cnt_r) |-> wd_flag_r && !$past(wd_flag_r))
    else $error("watchdog count moved without a rising edge");

  a_pair_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.operation == OP_TICK && pair_r |=>
      cmp_a_r[2] == cmp_a_r[1] && cmp_b_r[2] == cmp_b_r[1])
    else $error("pair mode compares differ");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmp_a_r[0] != '0 && cmp_b_r[0] != '0) && !(cmp_a_r[1] != '0 && cmp_b_r[1] != '0))
    else $error("both drive sides active");

  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r[0] <= 16'sd32640 && act_r[0] >= -16'sd32640 &&
    act_r[1] <= 16'sd32640 && act_r[1] >= -16'sd32640)
    else $error("actual value out of range");

endmodule

// ===== test/tb_slew_limited_motor_pwm_core.sv =====
module tb_slew_limited_motor_pwm_core;
  timeunit 1ns;
  timeprecision 1ps;
  import slmp_pkg::*;

  localparam logic [OP_W-1:0]   OP_NONE    = 2'd3;  // unused operation code
  localparam logic [PORT_W-1:0] PORT_NONE  = 2'd3;  // no channel behind it
  localparam int                GOAL_FLOOR = -(2 ** (GOAL_W - 1) - 1);
  localparam int                N_PHASES   = 7;
  localparam int                PHASE_ITEMS = 145;
  localparam int                SETTLE     = 3;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [PORT_W-1:0]        port;
    logic signed [GOAL_W-1:0] goal;
    logic                     en;
    logic                     estop;
    logic [TIME_W-1:0]        now;
  } cmd_t;

  typedef struct {
    logic [CMP_W-1:0] cmp_a0;
    logic [CMP_W-1:0] cmp_b0;
    logic [CMP_W-1:0] cmp_a1;
    logic [CMP_W-1:0] cmp_b1;
    logic [CMP_W-1:0] cmp_a2;
    logic [CMP_W-1:0] cmp_b2;
    logic [NCH-1:0]   enable_bits;
    logic             watchdog_active;
    logic [CNT_W-1:0] watchdog_events;
  } status_t;

  class pwm_predictor;
    logic [TMO_W-1:0]  timeout_us;
    logic [SLEW_W-1:0] slew[NCH];
    logic              pair;
    int                goal[NCH];
    int                actual[NCH];
    logic [NCH-1:0]    enable;
    logic [TIME_W-1:0] last_cmd_us;
    logic              wd_active;
    logic [CNT_W-1:0]  wd_events;
    logic [15:0]       cmp[2*NCH];
    status_t           expected_status[$];
    int                errors;

    function new();
      timeout_us  = TIMEOUT_RST;
      pair        = 1'b1;
      enable      = '0;
      last_cmd_us = '0;
      wd_active   = 1'b0;
      wd_events   = '0;
      errors      = 0;
      for (int i = 0; i < NCH; i++) begin
        slew[i]   = SLEW_RST;
        goal[i]   = 0;
        actual[i] = 0;
      end
      for (int i = 0; i < 2*NCH; i++) cmp[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TMO_W-1:0] data);
      case (idx)
        REG_TIMEOUT: timeout_us = data;
        REG_SLEW0:   slew[0] = data[SLEW_W-1:0];
        REG_SLEW1:   slew[1] = data[SLEW_W-1:0];
        REG_SLEW2:   slew[2] = data[SLEW_W-1:0];
        REG_PAIR:    pair = data[0];
        default: ;
      endcase
    endfunction

    function void advance_tick(logic [TIME_W-1:0] now, logic estop);
      logic [TIME_W-1:0] elapsed;
      logic fire;
      logic halt;
      int target;
      int delta;
      int lim;
      int duty;
      elapsed = now - last_cmd_us;  // wraps at 48 bits
      fire = (timeout_us != '0) && (elapsed > TIME_W'(timeout_us));
      halt = estop || fire;
      if (fire && !wd_active) wd_events++;
      wd_active = fire;
      for (int i = 0; i < NCH; i++) begin
        target = halt ? 0 : goal[i] * (1 << FRAC_BITS);
        delta  = target - actual[i];
        lim    = int'(slew[i]);
        if (halt && lim < int'(STOP_MIN_SLEW)) lim = int'(STOP_MIN_SLEW);
        if (delta < -lim) delta = -lim;
        if (delta > lim) delta = lim;
        actual[i] += delta;
        duty = actual[i] >>> FRAC_BITS;  // floor, so tiny negatives give -1
        if (duty >= 0) begin
          cmp[2*i]   = 16'(duty * (PWM_PERIOD / 256));
          cmp[2*i+1] = '0;
        end else begin
          cmp[2*i]   = '0;
          cmp[2*i+1] = 16'(-duty * (PWM_PERIOD / 256));
        end
      end
      if (pair) begin
        cmp[4] = cmp[2];
        cmp[5] = cmp[3];
      end
    endfunction

    function void take_command(cmd_t c);
      int g;
      status_t s;
      case (c.op)
        OP_TICK: advance_tick(c.now, c.estop);
        OP_GOAL: begin
          if (c.port < NCH) begin
            g = c.goal;
            if (g < GOAL_FLOOR) g = GOAL_FLOOR;
            goal[c.port] = g;
            last_cmd_us = c.now;
          end
        end
        OP_ENABLE: begin
          if (c.port < NCH) begin
            // pair copy only on an actual change of channel 1
            if (c.en != enable[c.port]) begin
              enable[c.port] = c.en;
              if (pair && c.port == 1) enable[2] = c.en;
            end
            last_cmd_us = c.now;
          end
        end
        default: ;
      endcase
      s.cmp_a0          = cmp[0][CMP_W-1:0];
      s.cmp_b0          = cmp[1][CMP_W-1:0];
      s.cmp_a1          = cmp[2][CMP_W-1:0];
      s.cmp_b1          = cmp[3][CMP_W-1:0];
      s.cmp_a2          = cmp[4][CMP_W-1:0];
      s.cmp_b2          = cmp[5][CMP_W-1:0];
      s.enable_bits     = enable;
      s.watchdog_active = wd_active;
      s.watchdog_events = wd_events;
      expected_status.push_back(s);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      want = expected_status.pop_front();
      check_field("cmp_a0", 16'(want.cmp_a0), 16'(got.cmp_a0));
      check_field("cmp_b0", 16'(want.cmp_b0), 16'(got.cmp_b0));
      check_field("cmp_a1", 16'(want.cmp_a1), 16'(got.cmp_a1));
      check_field("cmp_b1", 16'(want.cmp_b1), 16'(got.cmp_b1));
      check_field("cmp_a2", 16'(want.cmp_a2), 16'(got.cmp_a2));
      check_field("cmp_b2", 16'(want.cmp_b2), 16'(got.cmp_b2));
      check_field("enable_bits", 16'(want.enable_bits), 16'(got.enable_bits));
      check_field("watchdog_active", 16'(want.watchdog_active), 16'(got.watchdog_active));
      check_field("watchdog_events", 16'(want.watchdog_events), 16'(got.watchdog_events));
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  slmp_in_if  in_if ();
  slmp_out_if out_if ();
  slmp_cfg_if cfg_if ();

  slew_limited_motor_pwm_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pwm_predictor      predictor = new();
  logic [TIME_W-1:0] t_us;
  int                burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[slew_limited_motor_pwm_core] ERROR");
    $finish;
  end

  // result side stalls follow their own pattern, switching style now and then
  initial begin
    int stall_mode;
    int mode_left;
    int beat_cnt;
    out_if.ready <= 1'b0;
    stall_mode = 0;
    mode_left  = 0;
    beat_cnt   = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(40, 200);
      end
      mode_left--;
      beat_cnt++;
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ((beat_cnt % 7) >= 3);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    cmd_t    seen_cmd;
    status_t seen_status;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) predictor.set_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        seen_cmd = '{op: in_if.operation, port: in_if.port, goal: in_if.goal_pwm,
                     en: in_if.enable_value, estop: in_if.estop, now: in_if.now_us};
        predictor.take_command(seen_cmd);
      end
      if (out_if.valid && out_if.ready) begin
        seen_status = '{cmp_a0: out_if.cmp_a0, cmp_b0: out_if.cmp_b0,
                        cmp_a1: out_if.cmp_a1, cmp_b1: out_if.cmp_b1,
                        cmp_a2: out_if.cmp_a2, cmp_b2: out_if.cmp_b2,
                        enable_bits: out_if.enable_bits,
                        watchdog_active: out_if.watchdog_active,
                        watchdog_events: out_if.watchdog_events};
        predictor.compare_result(seen_status);
      end
    end
  end

  function automatic cmd_t mk_cmd(logic [OP_W-1:0] op, logic [PORT_W-1:0] port,
                                  logic signed [GOAL_W-1:0] goal, logic en, logic estop,
                                  logic [TIME_W-1:0] now);
    cmd_t c;
    c = '{op: op, port: port, goal: goal, en: en, estop: estop, now: now};
    return c;
  endfunction

  // valid stays high through a burst; a gap follows once the burst runs out
  task automatic send_cmd(input cmd_t c);
    in_if.valid        <= 1'b1;
    in_if.operation    <= c.op;
    in_if.port         <= c.port;
    in_if.goal_pwm     <= c.goal;
    in_if.enable_value <= c.en;
    in_if.estop        <= c.estop;
    in_if.now_us       <= c.now;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TMO_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
  endtask

  task automatic program_regs(input logic [TMO_W-1:0] tmo, input logic [TMO_W-1:0] s0,
                              input logic [TMO_W-1:0] s1, input logic [TMO_W-1:0] s2,
                              input logic [TMO_W-1:0] pair_word, input bit spare);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_SLEW0, s0);
    write_reg(REG_SLEW1, s1);
    write_reg(REG_SLEW2, s2);
    write_reg(REG_PAIR, pair_word);
    // unmapped indexes must leave everything alone
    if (spare) begin
      for (int r = int'(REG_PAIR) + 1; r < (1 << CFG_IDX_W); r++)
        write_reg(CFG_IDX_W'(r), TMO_W'($urandom));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // runs of mixed commands and ticks, with tick-only quiet runs to let the watchdog bite
  task automatic run_phase(input int n_items);
    int   done;
    int   run_len;
    int   pick;
    bit   quiet;
    bit   stop_run;
    bit   ignored;
    cmd_t c;
    done = 0;
    while (done < n_items) begin
      quiet    = ($urandom_range(0, 3) == 0);
      stop_run = ($urandom_range(0, 7) == 0);
      run_len  = quiet ? $urandom_range(3, 12) : $urandom_range(4, 16);
      repeat (run_len) begin
        pick    = quiet ? 0 : $urandom_range(0, 99);
        ignored = 1'b0;
        c = mk_cmd(OP_TICK, PORT_W'($urandom), GOAL_W'($urandom), 1'($urandom),
                   stop_run || ($urandom_range(0, 15) == 0), t_us);
        if (pick < 40) begin
          t_us += TIME_W'(900 + $urandom_range(0, 200));
          c.now = t_us;
        end else if (pick < 90) begin
          c.op   = (pick < 65) ? OP_GOAL : OP_ENABLE;
          c.port = PORT_W'($urandom_range(0, NCH - 1));
          t_us  += TIME_W'($urandom_range(0, 300));
          c.now  = t_us;
        end else if (pick < 96) begin
          c.op = $urandom_range(0, 1) ? OP_NONE : ($urandom_range(0, 1) ? OP_GOAL : OP_ENABLE);
          if (c.op != OP_NONE) c.port = PORT_NONE;
          c.now   = TIME_W'({$urandom, $urandom});
          ignored = 1'b1;
        end else begin
          c.op  = OP_W'($urandom_range(0, 2));
          c.now = TIME_W'({$urandom, $urandom});
        end
        send_cmd(c);
        if (!ignored) done++;
      end
    end
  endtask

  initial begin
    logic [TMO_W-1:0] tmo;
    logic [TMO_W-1:0] sl[NCH];
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OP_TICK;
    in_if.port         <= '0;
    in_if.goal_pwm     <= '0;
    in_if.enable_value <= 1'b0;
    in_if.estop        <= 1'b0;
    in_if.now_us       <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_TIMEOUT;
    cfg_if.data        <= '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1 s timeout, slew 384, pair on
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, 48'd1000));
    send_cmd(mk_cmd(OP_GOAL, 0, 255, 0, 0, 48'd1100));
    send_cmd(mk_cmd(OP_GOAL, 1, -256, 0, 0, 48'd1200));      // saturates
    send_cmd(mk_cmd(OP_GOAL, 2, -255, 0, 0, 48'd1300));
    send_cmd(mk_cmd(OP_ENABLE, 0, 0, 1, 0, 48'd1350));
    send_cmd(mk_cmd(OP_ENABLE, 1, 0, 1, 0, 48'd1400));       // copied to ch2
    send_cmd(mk_cmd(OP_ENABLE, 1, 0, 1, 0, 48'd1420));       // no change
    send_cmd(mk_cmd(OP_ENABLE, 2, 0, 0, 0, 48'd1500));       // ch2 direct
    send_cmd(mk_cmd(OP_GOAL, PORT_NONE, 100, 1, 1, 48'd1600));
    send_cmd(mk_cmd(OP_ENABLE, PORT_NONE, -1, 1, 1, 48'd1650));
    send_cmd(mk_cmd(OP_NONE, PORT_NONE, -1, 1, 1, 48'd1700));
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, 48'd2000));
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, 48'd3000));
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 1, 48'd4000));
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, 48'd5000));
    t_us = 48'd1500 + TIME_W'(TIMEOUT_RST);
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, t_us));               // exactly at timeout
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, t_us + 48'd1));        // one past: fires
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, t_us + 48'd1001));
    send_cmd(mk_cmd(OP_GOAL, 0, -1, 0, 1, t_us + 48'd1201));
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, t_us + 48'd2201));
    t_us = '1 - 48'd299;
    send_cmd(mk_cmd(OP_ENABLE, 0, 0, 0, 0, t_us));
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, 48'd700));             // across the wrap
    t_us = t_us + 48'd1000001;
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, t_us));
    t_us = t_us + 48'd1000;
    send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, t_us));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: program_regs('0, '0, '0, '0, '0, 1'b1);
        1: program_regs('1, 31'h7FFF_FFFF, 31'h0000_FFFF, 31'h5555_FFFF, 31'h7FFF_FFFF, 1'b0);
        2: program_regs(31'd2500, TMO_W'($urandom_range(1, 16)),
                        TMO_W'($urandom_range(1, 16)), TMO_W'($urandom_range(1, 16)),
                        31'd1, 1'b0);
        3: program_regs(31'd1, SLEW_RST, SLEW_RST, SLEW_RST, 31'd0, 1'b0);
        default: begin
          case ($urandom_range(0, 2))
            0:       tmo = TMO_W'($urandom_range(1500, 6000));
            1:       tmo = TIMEOUT_RST;
            default: tmo = TMO_W'($urandom);
          endcase
          for (int i = 0; i < NCH; i++)
            sl[i] = $urandom_range(0, 1) ? TMO_W'($urandom_range(0, 1000)) : TMO_W'($urandom);
          program_regs(tmo, sl[0], sl[1], sl[2], TMO_W'($urandom), 1'b0);
        end
      endcase
      if (ph == 4) t_us = '1 - 48'd30000;  // roll the time base over during this phase
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (predictor.errors == 0)
      $display("[slew_limited_motor_pwm_core] OK");
    else
      $display("[slew_limited_motor_pwm_core] ERROR");
    $finish;
  end

endmodule
